FILE: rtl/mrope_pkg.sv
// Shared types, constants and helpers for the three-axis rotary position generator.
// No dependencies; every other file imports this package.
`default_nettype none

package mrope_pkg;

   localparam int MAX_IMAGES = 16;
   localparam int IDX_W      = $clog2(MAX_IMAGES);
   localparam int CNT_W      = $clog2(MAX_IMAGES + 1);
   localparam int POS_BITS   = 20;
   localparam int TOKEN_W    = 18;
   localparam int DIM_IN_W   = 7;
   localparam int FRM_IN_W   = 6;
   localparam int COL_W      = 6;
   localparam int ROW_W      = 6;
   localparam int FRM_W      = 5;
   localparam int MAX_DIM    = 64;
   localparam int MAX_FRAMES = 32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IMG_BASE = 1'b0;
   localparam logic [TOKEN_W-1:0] IMG_BASE_RST = TOKEN_W'(65536);

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_TOKEN  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK            = 2'd0,
      ERR_NO_GRID       = 2'd1,
      ERR_TEXT_IN_IMAGE = 2'd2,
      ERR_SATURATED     = 2'd3
   } err_type;

   typedef struct packed {
      logic [FRM_W-1:0] frames_m1;
      logic [ROW_W-1:0] rows_m1;
      logic [COL_W-1:0] cols_m1;
   } grid_entry_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     addr;
      grid_entry_type       data;
   } table_wr_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [TOKEN_W-1:0]  token_id;
      logic [DIM_IN_W-1:0] grid_cols;
      logic [DIM_IN_W-1:0] grid_rows;
      logic [FRM_IN_W-1:0] grid_frames;
      logic                new_batch;
      logic                new_sequence;
   } req_type;

   typedef struct packed {
      logic [POS_BITS-1:0] pos_time;
      logic [POS_BITS-1:0] pos_row;
      logic [POS_BITS-1:0] pos_col;
      err_type             error;
   } rsp_type;

   // size minus one, 0 kept as 0, oversize pinned to the top entry
   function automatic logic [COL_W-1:0] clamp_dim(logic [DIM_IN_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v == '0) r = '0;
      else if (v > DIM_IN_W'(MAX_DIM)) r = COL_W'(MAX_DIM - 1);
      else r = COL_W'(v - DIM_IN_W'(1));
      return r;
   endfunction

   function automatic logic [FRM_W-1:0] clamp_frames(logic [FRM_IN_W-1:0] v);
      logic [FRM_W-1:0] r;
      if (v == '0) r = '0;
      else if (v > FRM_IN_W'(MAX_FRAMES)) r = FRM_W'(MAX_FRAMES - 1);
      else r = FRM_W'(v - FRM_IN_W'(1));
      return r;
   endfunction

   function automatic logic [POS_BITS-1:0] sat_pos(logic [POS_BITS:0] v);
      return v[POS_BITS] ? {POS_BITS{1'b1}} : v[POS_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/multimodal_rope_position_ids.sv
// Top level: input register, position core, grid table, result register, APB CSR.
// Depends on mrope_pkg, mrope_grid_table, mrope_pos_core.
`default_nettype none

// Three-axis rotary position generator. An accepted item sits in the input
// register while the core's logic works on it, and its result is loaded into
// the result register as the item leaves the input register; rsp_valid then
// rises. One item per cycle sustained while results are taken. The running time and walk
// counters update in that single step, so a token sees the state left by the
// token right before it. Grid and clear items produce no result and pass even
// while a result waits; a waiting result stalls only a token item. The grid
// table holds MAX_IMAGES entries and needs no clearing after reset.
// CSR: first image token id at byte address 0.
module multimodal_rope_position_ids
   import mrope_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_kind,
   input  wire logic [TOKEN_W-1:0]    req_token_id,
   input  wire logic [DIM_IN_W-1:0]   req_grid_cols,
   input  wire logic [DIM_IN_W-1:0]   req_grid_rows,
   input  wire logic [FRM_IN_W-1:0]   req_grid_frames,
   input  wire logic                  req_new_batch,
   input  wire logic                  req_new_sequence,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [POS_BITS-1:0]        rsp_pos_time,
   output logic [POS_BITS-1:0]        rsp_pos_row,
   output logic [POS_BITS-1:0]        rsp_pos_col,
   output logic [1:0]                 rsp_error,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic               in_valid_ff, in_valid_in;
   req_type            in_req_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_rsp_ff;
   logic [TOKEN_W-1:0] img_base_ff, img_base_in;

   logic           has_result, advance, csr_wr;
   rsp_type        core_rsp;
   table_wr_type   tbl_wr;
   logic [IDX_W-1:0] rd_index;
   grid_entry_type rd_entry;

   // CSR
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign img_base_in = (csr_wr && paddr[2] == CSR_IMG_BASE) ?
                        pwdata[TOKEN_W-1:0] : img_base_ff;
   assign prdata = (paddr[2] == CSR_IMG_BASE) ?
                   CSR_DATA_W'(img_base_ff) : '0;

   // handshake: an item leaves the input register when it has no result or its result has room
   assign has_result  = (in_req_ff.kind == KIND_TOKEN);
   assign advance     = in_valid_ff && (!has_result || !out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && has_result) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         img_base_ff  <= IMG_BASE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         img_base_ff  <= img_base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff.kind         <= req_kind;
         in_req_ff.token_id     <= req_token_id;
         in_req_ff.grid_cols    <= req_grid_cols;
         in_req_ff.grid_rows    <= req_grid_rows;
         in_req_ff.grid_frames  <= req_grid_frames;
         in_req_ff.new_batch    <= req_new_batch;
         in_req_ff.new_sequence <= req_new_sequence;
      end
      if (advance && has_result) begin
         out_rsp_ff <= core_rsp;
      end
   end

   mrope_grid_table u_table (
      .clock    (clock),
      .wr       (tbl_wr),
      .rd_index (rd_index),
      .rd_entry (rd_entry)
   );

   mrope_pos_core u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .req            (in_req_ff),
      .img_base       (img_base_ff),
      .rd_entry       (rd_entry),
      .rd_index       (rd_index),
      .tbl_wr         (tbl_wr),
      .rsp            (core_rsp)
   );

   assign rsp_valid    = out_valid_ff;
   assign rsp_pos_time = out_rsp_ff.pos_time;
   assign rsp_pos_row  = out_rsp_ff.pos_row;
   assign rsp_pos_col  = out_rsp_ff.pos_col;
   assign rsp_error    = out_rsp_ff.error;

endmodule

`default_nettype wire

FILE: rtl/mrope_grid_table.sv
// Grid size table: MAX_IMAGES flop entries, one write port, one read port.
// Depends on mrope_pkg.
`default_nettype none

module mrope_grid_table
   import mrope_pkg::*;
(
   input  wire logic           clock,
   input  wire table_wr_type   wr,
   input  wire logic [IDX_W-1:0] rd_index,
   output grid_entry_type      rd_entry
);

   grid_entry_type entry_ff [MAX_IMAGES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_ff[wr.addr] <= wr.data;
      end
   end

   assign rd_entry = entry_ff[rd_index];

endmodule

`default_nettype wire

FILE: rtl/mrope_pos_core.sv
// Position state (running time, table fill and read index, image walk counters)
// and the per-item next-state and result logic. Depends on mrope_pkg.
`default_nettype none

module mrope_pos_core
   import mrope_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire req_type             req,
   input  wire logic [TOKEN_W-1:0]  img_base,
   input  wire grid_entry_type      rd_entry,
   output logic [IDX_W-1:0]         rd_index,
   output table_wr_type             tbl_wr,
   output rsp_type                  rsp
);

   logic [POS_BITS-1:0] rt_ff, rt_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                img_ff, img_in;
   logic [FRM_W-1:0]    fc_ff, fc_in;
   logic [ROW_W-1:0]    rc_ff, rc_in;
   logic [COL_W-1:0]    cc_ff, cc_in;

   logic [POS_BITS-1:0] t;
   logic [CNT_W-1:0]    idx0, idx_m1;
   logic                img0, is_image, no_grid;
   logic [FRM_W-1:0]    fc_eff;
   logic [ROW_W-1:0]    rc_eff;
   logic [COL_W-1:0]    cc_eff;
   logic                col_more, row_more, frm_more;
   logic [COL_W-1:0]    dim_max;
   logic [POS_BITS:0]   sum_row, sum_col, sum_one, sum_max;
   logic                img_sat;

   // item-start adjustments: new_sequence zeroes time, new_batch drops the walk
   assign t      = req.new_sequence ? '0 : rt_ff;
   assign idx0   = req.new_batch ? '0 : idx_ff;
   assign img0   = req.new_batch ? 1'b0 : img_ff;
   assign idx_m1 = idx0 - CNT_W'(1);
   assign rd_index = img0 ? idx_m1[IDX_W-1:0] : idx0[IDX_W-1:0];

   assign is_image = (req.token_id >= img_base);
   assign no_grid  = !img0 && (idx0 >= cnt_ff);

   assign fc_eff = img0 ? fc_ff : '0;
   assign rc_eff = img0 ? rc_ff : '0;
   assign cc_eff = img0 ? cc_ff : '0;

   assign col_more = cc_eff < rd_entry.cols_m1;
   assign row_more = rc_eff < rd_entry.rows_m1;
   assign frm_more = fc_eff < rd_entry.frames_m1;
   assign dim_max  = (rd_entry.rows_m1 > rd_entry.cols_m1) ? rd_entry.rows_m1 : rd_entry.cols_m1;

   assign sum_row = {1'b0, t} + (POS_BITS+1)'(rc_eff);
   assign sum_col = {1'b0, t} + (POS_BITS+1)'(cc_eff);
   assign sum_one = {1'b0, t} + (POS_BITS+1)'(1);
   assign sum_max = {1'b0, t} + (POS_BITS+1)'(dim_max) + (POS_BITS+1)'(1);

   assign img_sat = sum_row[POS_BITS] | sum_col[POS_BITS] |
                    (!col_more && !row_more && (frm_more ? sum_one[POS_BITS]
                                                         : sum_max[POS_BITS]));

   // result of a token item
   always_comb begin
      rsp.pos_time = t;
      rsp.pos_row  = t;
      rsp.pos_col  = t;
      rsp.error    = ERR_OK;
      if (!is_image) begin
         if (img0) rsp.error = ERR_TEXT_IN_IMAGE;
         else if (sum_one[POS_BITS]) rsp.error = ERR_SATURATED;
      end else if (no_grid) begin
         rsp.error = ERR_NO_GRID;
      end else begin
         rsp.pos_row = sat_pos(sum_row);
         rsp.pos_col = sat_pos(sum_col);
         if (img_sat) rsp.error = ERR_SATURATED;
      end
   end

   // next state
   always_comb begin
      rt_in  = rt_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      img_in = img_ff;
      fc_in  = fc_ff;
      rc_in  = rc_ff;
      cc_in  = cc_ff;
      tbl_wr.en   = 1'b0;
      tbl_wr.addr = cnt_ff[IDX_W-1:0];
      tbl_wr.data.cols_m1   = clamp_dim(req.grid_cols);
      tbl_wr.data.rows_m1   = clamp_dim(req.grid_rows);
      tbl_wr.data.frames_m1 = clamp_frames(req.grid_frames);
      if (fire) begin
         case (req.kind)
            KIND_CLEAR: begin
               cnt_in = '0;
               idx_in = '0;
               img_in = 1'b0;
            end
            KIND_APPEND: begin
               if (cnt_ff < CNT_W'(MAX_IMAGES)) begin
                  tbl_wr.en = 1'b1;
                  cnt_in    = cnt_ff + CNT_W'(1);
               end
            end
            KIND_TOKEN: begin
               rt_in  = t;
               idx_in = idx0;
               img_in = img0;
               if (!is_image) begin
                  img_in = 1'b0;
                  rt_in  = sat_pos(sum_one);
               end else if (!no_grid) begin
                  img_in = 1'b1;
                  if (!img0) idx_in = idx0 + CNT_W'(1);
                  fc_in = fc_eff;
                  rc_in = rc_eff;
                  cc_in = cc_eff;
                  if (col_more) begin
                     cc_in = cc_eff + COL_W'(1);
                  end else begin
                     cc_in = '0;
                     if (row_more) begin
                        rc_in = rc_eff + ROW_W'(1);
                     end else begin
                        rc_in = '0;
                        if (frm_more) begin
                           fc_in = fc_eff + FRM_W'(1);
                           rt_in = sat_pos(sum_one);
                        end else begin
                           fc_in  = '0;
                           img_in = 1'b0;
                           rt_in  = sat_pos(sum_max);
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_ff  <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
         img_ff <= 1'b0;
         fc_ff  <= '0;
         rc_ff  <= '0;
         cc_ff  <= '0;
      end else begin
         rt_ff  <= rt_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         img_ff <= img_in;
         fc_ff  <= fc_in;
         rc_ff  <= rc_in;
         cc_ff  <= cc_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mrope_checker.sv
// Port-level checks for the rotary position generator, bound to the top level.
// Depends on mrope_pkg.
`default_nettype none

module mrope_checker
   import mrope_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [POS_BITS-1:0] rsp_pos_time,
   input wire logic [POS_BITS-1:0] rsp_pos_row,
   input wire logic [POS_BITS-1:0] rsp_pos_col,
   input wire logic [1:0]          rsp_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_time) &&
      $stable(rsp_pos_row) && $stable(rsp_pos_col) && $stable(rsp_error))
      else $error("result changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // row and column are time plus a nonnegative offset, saturated
   a_offsets: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pos_row >= rsp_pos_time && rsp_pos_col >= rsp_pos_time)
      else $error("row or column below time");

   // text-like results carry the time on all three axes
   a_flat_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error == ERR_NO_GRID || rsp_error == ERR_TEXT_IN_IMAGE)
      |-> rsp_pos_row == rsp_pos_time && rsp_pos_col == rsp_pos_time)
      else $error("flat position expected");

endmodule

bind multimodal_rope_position_ids mrope_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_pos_time (rsp_pos_time),
   .rsp_pos_row  (rsp_pos_row),
   .rsp_pos_col  (rsp_pos_col),
   .rsp_error    (rsp_error)
);

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for multimodal_rope_position_ids: directed and random token streams,
// predicted in step with accepted items and checked field by field at the result port.
// Depends on mrope_pkg and the RTL of the block; reads no files.
module tb
   import mrope_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int unsigned TOKEN_MAX = (1 << TOKEN_W) - 1;
   localparam int unsigned POS_MAX = (1 << POS_BITS) - 1;
   localparam logic [CSR_ADDR_W-1:0] IMG_BASE_ADDR = CSR_ADDR_W'(4 * CSR_IMG_BASE);
   localparam int unsigned SETTLE_CYCLES = 6;   // two-register pipeline plus margin
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned PHASE_ITEMS = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_kind = KIND_CLEAR;
   logic [TOKEN_W-1:0]    req_token_id = '0;
   logic [DIM_IN_W-1:0]   req_grid_cols = '0;
   logic [DIM_IN_W-1:0]   req_grid_rows = '0;
   logic [FRM_IN_W-1:0]   req_grid_frames = '0;
   logic                  req_new_batch = 1'b0;
   logic                  req_new_sequence = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [POS_BITS-1:0]   rsp_pos_time;
   logic [POS_BITS-1:0]   rsp_pos_row;
   logic [POS_BITS-1:0]   rsp_pos_col;
   logic [1:0]            rsp_error;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   multimodal_rope_position_ids dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_token_id(req_token_id),
      .req_grid_cols(req_grid_cols), .req_grid_rows(req_grid_rows),
      .req_grid_frames(req_grid_frames), .req_new_batch(req_new_batch),
      .req_new_sequence(req_new_sequence),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pos_time(rsp_pos_time), .rsp_pos_row(rsp_pos_row),
      .rsp_pos_col(rsp_pos_col), .rsp_error(rsp_error),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [TOKEN_W-1:0]  img_base = IMG_BASE_RST;
   logic [POS_BITS-1:0] run_time = '0;
   grid_entry_type      grid_mem [MAX_IMAGES];
   int unsigned         grid_count = 0;
   int unsigned         read_idx = 0;
   bit                  in_img = 1'b0;
   int unsigned         frame_cnt = 0;
   int unsigned         row_cnt = 0;
   int unsigned         col_cnt = 0;

   rsp_type     pending_positions [$];
   rsp_type     oldest;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned src_idle_pct = 0;
   int unsigned sink_stall_pct = 0;

   function automatic int unsigned size_m1(int unsigned v, int unsigned top);
      if (v == 0) return 0;
      if (v > top) return top - 1;
      return v - 1;
   endfunction

   function automatic logic [POS_BITS-1:0] clip_pos(int unsigned v, inout bit sat);
      if (v > POS_MAX) begin
         sat = 1'b1;
         return POS_BITS'(POS_MAX);
      end
      return POS_BITS'(v);
   endfunction

   // Advance the predictor by one accepted item; tokens queue their positions.
   function automatic void predict_positions(req_type it);
      rsp_type        exp;
      grid_entry_type ent;
      int unsigned    t, cols, rows, frames;
      bit             sat;
      exp = '0;
      sat = 1'b0;
      case (it.kind)
         KIND_CLEAR: begin
            grid_count = 0;
            read_idx = 0;
            in_img = 1'b0;
         end
         KIND_APPEND: begin
            if (grid_count < MAX_IMAGES) begin
               ent.cols_m1 = COL_W'(size_m1(it.grid_cols, MAX_DIM));
               ent.rows_m1 = ROW_W'(size_m1(it.grid_rows, MAX_DIM));
               ent.frames_m1 = FRM_W'(size_m1(it.grid_frames, MAX_FRAMES));
               grid_mem[grid_count] = ent;
               grid_count++;
            end
         end
         KIND_TOKEN: begin
            if (it.new_sequence) run_time = '0;
            if (it.new_batch) begin
               read_idx = 0;
               in_img = 1'b0;
            end
            t = run_time;
            exp.error = ERR_OK;
            if (it.token_id < img_base) begin
               if (in_img) begin
                  in_img = 1'b0;
                  exp.error = ERR_TEXT_IN_IMAGE;
               end
               exp.pos_row = POS_BITS'(t);
               exp.pos_col = POS_BITS'(t);
               run_time = clip_pos(t + 1, sat);
            end else if (!in_img && read_idx >= grid_count) begin
               exp.pos_row = POS_BITS'(t);
               exp.pos_col = POS_BITS'(t);
               exp.error = ERR_NO_GRID;
            end else begin
               if (!in_img) begin
                  in_img = 1'b1;
                  frame_cnt = 0;
                  row_cnt = 0;
                  col_cnt = 0;
                  read_idx++;
               end
               ent = grid_mem[(read_idx - 1) % MAX_IMAGES];
               cols = ent.cols_m1 + 1;
               rows = ent.rows_m1 + 1;
               frames = ent.frames_m1 + 1;
               exp.pos_row = clip_pos(t + row_cnt, sat);
               exp.pos_col = clip_pos(t + col_cnt, sat);
               if (col_cnt + 1 < cols) begin
                  col_cnt++;
               end else begin
                  col_cnt = 0;
                  if (row_cnt + 1 < rows) begin
                     row_cnt++;
                  end else begin
                     row_cnt = 0;
                     if (frame_cnt + 1 < frames) begin
                        frame_cnt++;
                        run_time = clip_pos(t + 1, sat);
                     end else begin
                        // image done: time jumps past the larger grid side
                        frame_cnt = 0;
                        in_img = 1'b0;
                        run_time = clip_pos(t + ((rows > cols) ? rows : cols), sat);
                     end
                  end
               end
            end
            if (exp.error == ERR_OK && sat) exp.error = ERR_SATURATED;
            exp.pos_time = POS_BITS'(t);
            pending_positions.insert(pending_positions.size(), exp);
         end
         default: ;
      endcase
   endfunction

   function automatic req_type make_token(logic [TOKEN_W-1:0] id, bit nb, bit ns);
      req_type it;
      it = '0;
      it.kind = KIND_TOKEN;
      it.token_id = id;
      it.new_batch = nb;
      it.new_sequence = ns;
      return it;
   endfunction

   function automatic req_type make_grid(int unsigned c, int unsigned r, int unsigned f);
      req_type it;
      it = '0;
      it.kind = KIND_APPEND;
      it.grid_cols = DIM_IN_W'(c);
      it.grid_rows = DIM_IN_W'(r);
      it.grid_frames = FRM_IN_W'(f);
      return it;
   endfunction

   function automatic req_type make_clear();
      req_type it;
      it = '0;
      it.kind = KIND_CLEAR;
      return it;
   endfunction

   // Mostly small grids so images finish; some thin tall-in-time ones and some full range.
   function automatic req_type rand_grid(bit tiny);
      int unsigned sel;
      sel = $urandom_range(99);
      if (tiny || sel < 70)
         return make_grid($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 2));
      if (sel < 85)
         return make_grid($urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(0, 63));
      return make_grid($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 63));
   endfunction

   function automatic req_type rand_token(bit image, bit first);
      logic [TOKEN_W-1:0] id;
      bit nb, ns;
      if (image || img_base == 0) id = TOKEN_W'($urandom_range(TOKEN_MAX, img_base));
      else id = TOKEN_W'($urandom_range(img_base - 1, 0));
      nb = first || ($urandom_range(29) == 0);
      ns = first ? 1'($urandom_range(1)) : ($urandom_range(29) == 0);
      return make_token(id, nb, ns);
   endfunction

   function automatic req_type rand_noise();
      req_type it;
      it.kind = 2'($urandom_range(3));
      it.token_id = TOKEN_W'($urandom);
      it.grid_cols = DIM_IN_W'($urandom);
      it.grid_rows = DIM_IN_W'($urandom);
      it.grid_frames = FRM_IN_W'($urandom);
      it.new_batch = 1'($urandom);
      it.new_sequence = 1'($urandom);
      return it;
   endfunction

   task automatic send_item(input req_type it);
      if ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_valid <= 1'b1;
      req_kind <= it.kind;
      req_token_id <= it.token_id;
      req_grid_cols <= it.grid_cols;
      req_grid_rows <= it.grid_rows;
      req_grid_frames <= it.grid_frames;
      req_new_batch <= it.new_batch;
      req_new_sequence <= it.new_sequence;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_positions(it);
   endtask

   // Hold off the sender until every queued result is back and the pipe is empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == IMG_BASE_ADDR) img_base = data[TOKEN_W-1:0];
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] exp);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== exp) begin
         $error("img_base: expected %0d, got %0d", exp, prdata);
         mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_img_base(input logic [TOKEN_W-1:0] v);
      csr_write(IMG_BASE_ADDR, CSR_DATA_W'(v));
      csr_check(IMG_BASE_ADDR, CSR_DATA_W'(v));
   endtask

   task automatic test_register_access();
      csr_check(IMG_BASE_ADDR, CSR_DATA_W'(IMG_BASE_RST));
      set_img_base('0);
      set_img_base(TOKEN_W'(TOKEN_MAX));
      set_img_base(IMG_BASE_RST);
   endtask

   task automatic test_directed_walks();
      send_item(make_token('0, 1'b1, 1'b1));
      send_item(make_token(TOKEN_W'(IMG_BASE_RST - 1), 1'b0, 1'b0));
      send_item(make_token(TOKEN_W'(TOKEN_MAX), 1'b0, 1'b0));       // image with empty table
      send_item('1);                                                 // unused kind, ignored
      send_item(make_clear());
      send_item(make_grid(0, 0, 0));                                 // zero sizes -> 1x1x1
      send_item(make_grid(127, 127, 63));                            // oversize -> 64x64x32
      send_item(make_grid(2, 2, 2));
      send_item(make_token(IMG_BASE_RST, 1'b0, 1'b0));
      send_item(make_token(TOKEN_W'(TOKEN_MAX), 1'b0, 1'b0));
      send_item(make_token(TOKEN_W'(TOKEN_MAX), 1'b0, 1'b0));
      send_item(make_token(TOKEN_W'(100), 1'b0, 1'b0));             // text breaks the walk
      repeat (8) send_item(make_token(TOKEN_W'(TOKEN_MAX), 1'b0, 1'b0));
      send_item(make_token(TOKEN_W'(TOKEN_MAX), 1'b0, 1'b0));       // table used up
      send_item(make_token(TOKEN_W'(TOKEN_MAX), 1'b1, 1'b1));       // restart at entry 0
   endtask

   // Prompts: optional clear, a few grids (now and then a full table), then tokens
   // that mostly walk the stored images; the rest is noise.
   task automatic test_random_traffic(input logic [TOKEN_W-1:0] start,
                                      input int unsigned idle_pct, input int unsigned stall_pct);
      req_type     it;
      int unsigned sent, n_grids, n_tok, min_tok, cap;
      bit          tiny, pick_image;
      wait_idle();
      set_img_base(start);
      src_idle_pct = idle_pct;
      sink_stall_pct = stall_pct;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         if ($urandom_range(99) < 10) begin
            it = rand_noise();
            send_item(it);
            if (it.kind != KIND_UNUSED) sent++;
         end else begin
            if ($urandom_range(3) != 0) begin
               send_item(make_clear());
               sent++;
            end
            tiny = ($urandom_range(19) == 0);
            n_grids = tiny ? $urandom_range(15, 18) : $urandom_range(0, 3);
            cap = tiny ? 150 : 80;
            repeat (n_grids) send_item(rand_grid(tiny));
            sent += n_grids;
            min_tok = $urandom_range(1, 5);
            n_tok = 0;
            while (n_tok < cap && (in_img || read_idx < grid_count || n_tok < min_tok)) begin
               if (in_img) pick_image = ($urandom_range(99) >= 2);
               else if (read_idx < grid_count) pick_image = ($urandom_range(99) < 50);
               else pick_image = ($urandom_range(99) < 15);
               send_item(rand_token(pick_image, n_tok == 0));
               n_tok++;
            end
            sent += n_tok;
         end
         if ($urandom_range(49) == 0) wait_idle();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_positions.size() == 0) begin
               $error("unexpected result: time %0d row %0d col %0d error %0d",
                      rsp_pos_time, rsp_pos_row, rsp_pos_col, rsp_error);
               mismatches++;
            end else begin
               oldest = pending_positions.pop_front();
               if (rsp_pos_time !== oldest.pos_time) begin
                  $error("pos_time: expected %0d, got %0d", oldest.pos_time, rsp_pos_time);
                  mismatches++;
               end
               if (rsp_pos_row !== oldest.pos_row) begin
                  $error("pos_row: expected %0d, got %0d", oldest.pos_row, rsp_pos_row);
                  mismatches++;
               end
               if (rsp_pos_col !== oldest.pos_col) begin
                  $error("pos_col: expected %0d, got %0d", oldest.pos_col, rsp_pos_col);
                  mismatches++;
               end
               if (rsp_error !== oldest.error) begin
                  $error("error: expected %0d, got %0d", oldest.error, rsp_error);
                  mismatches++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_directed_walks();
      test_random_traffic(IMG_BASE_RST, 0, 0);
      test_random_traffic('0, 61, 0);
      test_random_traffic(TOKEN_W'(TOKEN_MAX), 0, 61);
      test_random_traffic(TOKEN_W'($urandom_range(1, TOKEN_MAX - 1)), 7, 7);
      wait_idle();
      if (pending_positions.size() != 0) begin
         $error("%0d results never arrived", pending_positions.size());
         mismatches++;
      end
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
